// ===== rtl/wola_pkg.sv =====
// Shared types, sizes and codes for the weighted overlap-add block.
// No dependencies; the RTL files that use it refer to it by scoped names, the testbench imports it.
package wola_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);

  localparam int MODE_W   = 2;
  localparam int CIDX_W   = 10;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 40;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_SIZE      = 1'b1;
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 11'd1024;
  localparam logic [CFG_W-1:0] HOP_SIZE_RESET      = 11'd512;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic [CIDX_W-1:0]          coef_index;
    logic signed [SAMPLE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
    logic                       tail_last;
    logic                       flush_error;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_SWEEP
  } ctrl_state_t;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_TAIL,
    OP_ERROR
  } op_t;

  // one accepted word headed for the accumulate pipeline
  typedef struct packed {
    logic                       valid;
    op_t                        op;
    logic                       emit;
    logic                       last;
    logic [IDX_W-1:0]           slot;
    logic signed [SAMPLE_W-1:0] sample;
  } issue_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } sweep_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [ACC_W-1:0] data;
  } ring_wr_t;

endpackage

// ===== rtl/wola_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-first on an address collision; no dependencies.
module wola_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/wola_ctrl.sv =====
// Front-end control: config registers, frame position, ring base, tail count,
// result credits and the ring clearing sequencer. Uses wola_pkg.
module wola_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  wola_pkg::in_word_t              item,
  input  logic                            cfg_write,
  input  logic [wola_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wola_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            result_pop,
  input  logic                            pipe_busy,
  output wola_pkg::issue_t                issue,
  output logic [wola_pkg::IDX_W-1:0]      ring_raddr,
  output logic [wola_pkg::IDX_W-1:0]      coef_raddr,
  output logic                            coef_we,
  output logic [wola_pkg::IDX_W-1:0]      coef_waddr,
  output logic [wola_pkg::COEF_W-1:0]     coef_wdata,
  output wola_pkg::sweep_t                sweep
);

  localparam int SUM_W = wola_pkg::IDX_W + 1;

  logic [wola_pkg::CFG_W-1:0]      window_length;
  logic [wola_pkg::CFG_W-1:0]      hop_size;
  logic [wola_pkg::IDX_W-1:0]      ring_base;
  logic [wola_pkg::LEN_W-1:0]      frame_position;
  logic [wola_pkg::LEN_W-1:0]      tail_count;
  logic [wola_pkg::FIFO_CNT_W-1:0] outstanding;
  logic [wola_pkg::IDX_W-1:0]      sweep_addr;
  wola_pkg::ctrl_state_t           state, state_next;

  logic [wola_pkg::LEN_W-1:0] eff_len;
  logic [wola_pkg::LEN_W-1:0] eff_hop;
  logic [wola_pkg::LEN_W-1:0] pos_next;
  logic                       accept;
  logic                       has_result;
  logic                       start_clear;
  logic                       cidx_ok;

  // slot arithmetic modulo the ring size; base < MAX and offset <= MAX
  function automatic logic [wola_pkg::IDX_W-1:0] ring_add(
    input logic [wola_pkg::IDX_W-1:0] base,
    input logic [wola_pkg::LEN_W-1:0] off
  );
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(wola_pkg::MAX_WINDOW)) begin
      sum = sum - SUM_W'(wola_pkg::MAX_WINDOW);
    end
    return sum[wola_pkg::IDX_W-1:0];
  endfunction

  always_comb begin
    if (window_length == '0) begin
      eff_len = wola_pkg::LEN_W'(1);
    end else if (32'(window_length) > 32'(wola_pkg::MAX_WINDOW)) begin
      eff_len = wola_pkg::LEN_W'(wola_pkg::MAX_WINDOW);
    end else begin
      eff_len = wola_pkg::LEN_W'(window_length);
    end
    if (hop_size == '0) begin
      eff_hop = wola_pkg::LEN_W'(1);
    end else if (32'(hop_size) > 32'(eff_len)) begin
      eff_hop = eff_len;
    end else begin
      eff_hop = wola_pkg::LEN_W'(hop_size);
    end
  end

  assign item_stall = (state != wola_pkg::ST_RUN) ||
                      (outstanding == wola_pkg::FIFO_CNT_W'(wola_pkg::FIFO_DEPTH));
  assign accept     = item_valid && !item_stall;
  assign pos_next   = frame_position + wola_pkg::LEN_W'(1);
  assign cidx_ok    = 32'(item.coef_index) < 32'(wola_pkg::MAX_WINDOW);

  assign coef_waddr = wola_pkg::IDX_W'(item.coef_index);
  assign coef_wdata = item.value;
  assign coef_raddr = wola_pkg::IDX_W'(frame_position);
  assign ring_raddr = issue.slot;

  // decode of the word at the input
  always_comb begin
    issue.valid  = 1'b0;
    issue.op     = wola_pkg::OP_SAMPLE;
    issue.emit   = 1'b0;
    issue.last   = 1'b0;
    issue.slot   = ring_add(ring_base, frame_position);
    issue.sample = item.value;
    coef_we      = 1'b0;
    has_result   = 1'b0;
    start_clear  = 1'b0;
    unique case (item.mode)
      wola_pkg::MODE_LOAD: begin
        coef_we = accept && cidx_ok;
      end
      wola_pkg::MODE_SAMPLE: begin
        issue.valid = accept;
        issue.emit  = frame_position < eff_hop;
        has_result  = issue.emit;
      end
      wola_pkg::MODE_FLUSH: begin
        if (frame_position != '0) begin
          issue.valid = accept;
          issue.op    = wola_pkg::OP_ERROR;
          has_result  = 1'b1;
        end else if (tail_count == '0) begin
          start_clear = accept;
        end else begin
          issue.valid = accept;
          issue.op    = wola_pkg::OP_TAIL;
          issue.emit  = 1'b1;
          issue.last  = tail_count == wola_pkg::LEN_W'(1);
          has_result  = 1'b1;
          start_clear = accept && issue.last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= wola_pkg::WINDOW_LENGTH_RESET;
      hop_size       <= wola_pkg::HOP_SIZE_RESET;
      ring_base      <= '0;
      frame_position <= '0;
      tail_count     <= '0;
      outstanding    <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          wola_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data;
          wola_pkg::REG_HOP_SIZE:      hop_size      <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept && item.mode == wola_pkg::MODE_SAMPLE) begin
        if (pos_next >= eff_len) begin
          ring_base      <= ring_add(ring_base, eff_hop);
          frame_position <= '0;
          tail_count     <= eff_len - eff_hop;
        end else begin
          frame_position <= pos_next;
        end
      end
      if (accept && item.mode == wola_pkg::MODE_FLUSH && frame_position == '0) begin
        if (tail_count == '0 || issue.last) begin
          ring_base <= '0;
        end else begin
          ring_base <= ring_add(ring_base, wola_pkg::LEN_W'(1));
        end
        if (tail_count != '0) begin
          tail_count <= tail_count - wola_pkg::LEN_W'(1);
        end
      end
      outstanding <= outstanding
                   + wola_pkg::FIFO_CNT_W'(accept && has_result)
                   - wola_pkg::FIFO_CNT_W'(result_pop);
    end
  end

  // clearing sequencer: wait for ring traffic to settle, then zero every slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wola_pkg::ST_DRAIN;
      sweep_addr <= '0;
    end else begin
      state <= state_next;
      if (state == wola_pkg::ST_SWEEP) begin
        sweep_addr <= sweep_addr + wola_pkg::IDX_W'(1);
      end else begin
        sweep_addr <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    sweep.en   = 1'b0;
    sweep.addr = sweep_addr;
    unique case (state)
      wola_pkg::ST_RUN: begin
        if (start_clear) begin
          state_next = wola_pkg::ST_DRAIN;
        end
      end
      wola_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = wola_pkg::ST_SWEEP;
        end
      end
      wola_pkg::ST_SWEEP: begin
        sweep.en = 1'b1;
        if (sweep_addr == wola_pkg::IDX_W'(wola_pkg::MAX_WINDOW - 1)) begin
          state_next = wola_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = wola_pkg::ST_DRAIN;
      end
    endcase
  end

endmodule

// ===== rtl/wola_mac.sv =====
// Multiply-accumulate pipeline around the ring memory: multiply, add with
// write-back forwarding, then round and saturate. Uses wola_pkg.
module wola_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  wola_pkg::issue_t            issue,
  input  logic [wola_pkg::COEF_W-1:0] coef_rdata,
  input  logic [wola_pkg::ACC_W-1:0]  ring_rdata,
  input  wola_pkg::sweep_t            sweep,
  output wola_pkg::ring_wr_t          ring_wr,
  output logic                        pipe_busy,
  output logic                        push,
  output wola_pkg::out_word_t         push_word
);

  localparam int RND_W = wola_pkg::ACC_W + 1;
  localparam logic signed [RND_W-1:0] RND_BIAS = RND_W'(8192);
  localparam logic signed [RND_W-1:0] POS_LIM  = RND_W'(32767);
  localparam logic signed [RND_W-1:0] NEG_LIM  = -RND_W'(32768);

  // multiply stage
  logic                                b_valid;
  wola_pkg::op_t                       b_op;
  logic                                b_emit;
  logic                                b_last;
  logic [wola_pkg::IDX_W-1:0]          b_slot;
  logic signed [wola_pkg::SAMPLE_W-1:0] b_sample;
  logic signed [wola_pkg::PROD_W-1:0]  b_prod;

  // accumulate stage
  logic                                c_valid;
  wola_pkg::op_t                       c_op;
  logic                                c_emit;
  logic                                c_last;
  logic [wola_pkg::IDX_W-1:0]          c_slot;
  logic signed [wola_pkg::PROD_W-1:0]  c_prod;
  logic [wola_pkg::ACC_W-1:0]          c_acc;
  logic [wola_pkg::ACC_W-1:0]          acc_old;
  logic [wola_pkg::ACC_W-1:0]          sum;
  wola_pkg::ring_wr_t                  c_wr;

  // the two most recent ring writes, not yet visible in the read data
  wola_pkg::ring_wr_t                  wr1, wr2;

  // round stage
  logic                                d_valid;
  logic                                d_err;
  logic                                d_last;
  logic [wola_pkg::ACC_W-1:0]          d_acc;
  logic signed [RND_W-1:0]             rounded;
  logic signed [RND_W-1:0]             shifted;

  assign b_prod = b_sample * $signed(coef_rdata);

  always_comb begin
    if (wr1.en && wr1.addr == c_slot) begin
      acc_old = wr1.data;
    end else if (wr2.en && wr2.addr == c_slot) begin
      acc_old = wr2.data;
    end else begin
      acc_old = c_acc;
    end
    sum = acc_old + wola_pkg::ACC_W'(c_prod);

    c_wr.en   = c_valid && (c_op != wola_pkg::OP_ERROR);
    c_wr.addr = c_slot;
    c_wr.data = c_emit ? '0 : sum;

    if (sweep.en) begin
      ring_wr.en   = 1'b1;
      ring_wr.addr = sweep.addr;
      ring_wr.data = '0;
    end else begin
      ring_wr = c_wr;
    end
  end

  assign pipe_busy = b_valid || c_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      wr1     <= '0;
      wr2     <= '0;
    end else begin
      b_valid <= issue.valid;
      c_valid <= b_valid;
      d_valid <= c_valid && (c_op != wola_pkg::OP_SAMPLE || c_emit);
      wr1     <= ring_wr;
      wr2     <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    b_op     <= issue.op;
    b_emit   <= issue.emit;
    b_last   <= issue.last;
    b_slot   <= issue.slot;
    b_sample <= issue.sample;

    c_op   <= b_op;
    c_emit <= b_emit;
    c_last <= b_last;
    c_slot <= b_slot;
    c_acc  <= ring_rdata;
    // tail and error words add nothing
    c_prod <= (b_op == wola_pkg::OP_SAMPLE) ? b_prod : '0;

    d_acc  <= sum;
    d_err  <= c_op == wola_pkg::OP_ERROR;
    d_last <= c_last;
  end

  // Q3.29 to Q1.15: add half an lsb, arithmetic shift, clip
  assign rounded = RND_W'($signed(d_acc)) + RND_BIAS;
  assign shifted = rounded >>> 14;

  always_comb begin
    push_word = '0;
    if (d_err) begin
      push_word.flush_error = 1'b1;
    end else begin
      push_word.tail_last = d_last;
      if (shifted > POS_LIM) begin
        push_word.sample_out = 16'sh7fff;
        push_word.saturated  = 1'b1;
      end else if (shifted < NEG_LIM) begin
        push_word.sample_out = -16'sh8000;
        push_word.saturated  = 1'b1;
      end else begin
        push_word.sample_out = shifted[wola_pkg::SAMPLE_W-1:0];
      end
    end
  end

  assign push = d_valid;

endmodule

// ===== rtl/wola_fifo.sv =====
// Result queue between the pipeline and the output channel.
// Space is reserved by credits at the input, so a push always finds room. Uses wola_pkg.
module wola_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wola_pkg::out_word_t push_word,
  output logic                result_valid,
  input  logic                result_stall,
  output wola_pkg::out_word_t result
);

  wola_pkg::out_word_t             entries [wola_pkg::FIFO_DEPTH];
  logic [wola_pkg::FIFO_PTR_W-1:0] head;
  logic [wola_pkg::FIFO_PTR_W-1:0] tail;
  logic [wola_pkg::FIFO_CNT_W-1:0] count;
  logic                            pop;

  localparam logic [wola_pkg::FIFO_PTR_W-1:0] PTR_LAST =
    wola_pkg::FIFO_PTR_W'(wola_pkg::FIFO_DEPTH - 1);

  assign result_valid = count != '0;
  assign result       = entries[head];
  assign pop          = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PTR_LAST) ? '0 : tail + wola_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        head <= (head == PTR_LAST) ? '0 : head + wola_pkg::FIFO_PTR_W'(1);
      end
      count <= count + wola_pkg::FIFO_CNT_W'(push) - wola_pkg::FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_word;
    end
  end

endmodule

// ===== rtl/windowed_overlap_add_top.sv =====
// Weighted overlap-add synthesis: one word per clock when not stalled, each
// sample weighted by its window coefficient and accumulated into a 1024-slot
// ring memory. Uses wola_pkg, wola_ram, wola_ctrl, wola_mac and wola_fifo.
//
// Throughput is one input word per cycle (load, sample or flush) while input
// is not stalled. A result passes the ring and coefficient read with the
// multiply, accumulate with write-back, then round and saturate into the
// queue, and is offered on the output channel from there. Each slot update
// is a read-modify-write of the ring memory; back-to-back hits on one slot
// are served by forwarding the last two writes. The output queue holds 8
// results, and input is stalled once 8 results are accepted but not yet
// taken. After reset, and after each flush that ends the tail (or finds it
// empty), the ring is zeroed one slot per cycle; input stalls while the
// pipeline drains and the ring is zeroed. Configuration writes are
// accepted at any time, but should only be made with the block idle.
module windowed_overlap_add_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  wola_pkg::in_word_t             item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output wola_pkg::out_word_t            result,
  input  logic                           cfg_write,
  input  logic [wola_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wola_pkg::CFG_W-1:0]     cfg_data
);

  wola_pkg::issue_t            issue;
  wola_pkg::sweep_t            sweep;
  wola_pkg::ring_wr_t          ring_wr;
  wola_pkg::out_word_t         push_word;
  logic [wola_pkg::IDX_W-1:0]  ring_raddr;
  logic [wola_pkg::IDX_W-1:0]  coef_raddr;
  logic [wola_pkg::IDX_W-1:0]  coef_waddr;
  logic [wola_pkg::COEF_W-1:0] coef_wdata;
  logic [wola_pkg::COEF_W-1:0] coef_rdata;
  logic [wola_pkg::ACC_W-1:0]  ring_rdata;
  logic                        coef_we;
  logic                        pipe_busy;
  logic                        push;
  logic                        result_pop;

  assign result_pop = result_valid && !result_stall;

  wola_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .result_pop (result_pop),
    .pipe_busy  (pipe_busy),
    .issue      (issue),
    .ring_raddr (ring_raddr),
    .coef_raddr (coef_raddr),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .sweep      (sweep)
  );

  wola_ram #(
    .WIDTH (wola_pkg::COEF_W),
    .DEPTH (wola_pkg::MAX_WINDOW)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  wola_ram #(
    .WIDTH (wola_pkg::ACC_W),
    .DEPTH (wola_pkg::MAX_WINDOW)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_wr.en),
    .waddr (ring_wr.addr),
    .wdata (ring_wr.data),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  wola_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .coef_rdata (coef_rdata),
    .ring_rdata (ring_rdata),
    .sweep      (sweep),
    .ring_wr    (ring_wr),
    .pipe_busy  (pipe_busy),
    .push       (push),
    .push_word  (push_word)
  );

  wola_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_word    (push_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for windowed_overlap_add_top: random and directed words
// against a cycle-free overlap-add predictor, with random idling on both sides.
// Depends on wola_pkg and the windowed_overlap_add_top RTL.
`timescale 1ns / 100ps

module testbench;
  import wola_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_WORDS = 160;
  localparam int MAX_REPORTS = 10;
  localparam longint TIMEOUT_NS = 64'd8_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  in_word_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_word_t result;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  windowed_overlap_add_top DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // overlap-add state as the block should hold it
  logic [CFG_W-1:0] len_reg;
  logic [CFG_W-1:0] hop_reg;
  logic signed [COEF_W-1:0] coef_mem [MAX_WINDOW];
  logic [ACC_W-1:0] acc_ring [MAX_WINDOW];
  logic [IDX_W-1:0] ring_head;
  int unsigned frame_pos;
  int unsigned tail_left;
  out_word_t due_words[$];

  // stimulus side: pending words and a light shadow of frame progress
  in_word_t input_words[$];
  bit coef_set [MAX_WINDOW];
  int unsigned gen_pos;
  int unsigned gen_tail;
  int words_pushed;
  int real_words;
  int words_taken;
  int results_taken;
  int fail_count;
  bit word_taken;

  int tx_gap, tx_run, rx_gap, rx_run, hold_left;
  bit hold_done;

  function automatic int unsigned active_length();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_WINDOW) return MAX_WINDOW;
    return 32'(len_reg);
  endfunction

  function automatic int unsigned active_hop();
    if (hop_reg == 0) return 1;
    if (hop_reg > active_length()) return active_length();
    return 32'(hop_reg);
  endfunction

  // Q3.29 accumulator to Q1.15, round half up, clip
  function automatic out_word_t round_q15(logic [ACC_W-1:0] acc);
    logic signed [ACC_W:0] biased;
    logic signed [ACC_W-14:0] q;
    out_word_t r;
    biased = $signed({acc[ACC_W-1], acc}) + 8192;
    q = (ACC_W-13)'(biased >>> 14);
    r = '0;
    if (q > 32767) begin
      r.sample_out = 16'sh7FFF;
      r.saturated = 1'b1;
    end else if (q < -32768) begin
      r.sample_out = 16'sh8000;
      r.saturated = 1'b1;
    end else begin
      r.sample_out = q[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  task automatic clear_ring();
    foreach (acc_ring[i]) acc_ring[i] = '0;
    ring_head = '0;
  endtask

  task automatic overlap_add_word(in_word_t w);
    int unsigned len, hop, pos;
    logic [IDX_W-1:0] slot;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0] sum;
    out_word_t r;
    len = active_length();
    hop = active_hop();
    r = '0;
    case (w.mode)
      MODE_LOAD: begin
        coef_mem[w.coef_index] = w.value;
      end
      MODE_SAMPLE: begin
        pos = frame_pos;
        slot = ring_head + IDX_W'(pos);
        prod = $signed(w.value) * $signed(coef_mem[pos]);
        sum = acc_ring[slot] + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        if (pos < hop) begin
          due_words.insert(due_words.size(), round_q15(sum));
          acc_ring[slot] = '0;
        end else begin
          acc_ring[slot] = sum;
        end
        frame_pos = pos + 1;
        if (frame_pos >= len) begin
          ring_head = ring_head + IDX_W'(hop);
          frame_pos = 0;
          tail_left = len - hop;
        end
      end
      MODE_FLUSH: begin
        if (frame_pos != 0) begin
          r.flush_error = 1'b1;
          due_words.insert(due_words.size(), r);
        end else if (tail_left == 0) begin
          clear_ring();
        end else begin
          r = round_q15(acc_ring[ring_head]);
          acc_ring[ring_head] = '0;
          ring_head = ring_head + 1'b1;
          tail_left--;
          if (tail_left == 0) begin
            r.tail_last = 1'b1;
            clear_ring();
          end
          due_words.insert(due_words.size(), r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic note_fail(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  function automatic int draw_gap(inout int run_left);
    int r;
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      run_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // driver: present the next word at the falling edge, hold it while stalled
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!(item_valid && !word_taken)) begin
      word_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        item_valid <= 1'b0;
      end else if (input_words.size() > 0) begin
        item <= input_words.pop_front();
        item_valid <= 1'b1;
        tx_gap = draw_gap(tx_run);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      overlap_add_word(item);
      word_taken = 1'b1;
      words_taken++;
    end
  end

  // receiver stall, with one long hold-off once results flow and input is queued
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!hold_done && results_taken >= 200 && input_words.size() > 40) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      result_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      rx_gap = draw_gap(rx_run);
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && result_valid && !result_stall) begin
      results_taken++;
      if (due_words.size() == 0) begin
        note_fail($sformatf("result %0d with nothing due: sample %0d sat %0b last %0b err %0b",
                            results_taken, result.sample_out, result.saturated,
                            result.tail_last, result.flush_error));
      end else begin
        want = due_words.pop_front();
        if (result.sample_out !== want.sample_out || result.saturated !== want.saturated ||
            result.tail_last !== want.tail_last || result.flush_error !== want.flush_error)
          note_fail($sformatf({"result %0d: expected sample %0d sat %0b last %0b err %0b,",
                               " got sample %0d sat %0b last %0b err %0b"},
                              results_taken, want.sample_out, want.saturated, want.tail_last,
                              want.flush_error, result.sample_out, result.saturated,
                              result.tail_last, result.flush_error));
      end
    end
  end

  task automatic push_word(logic [MODE_W-1:0] mode, logic [CIDX_W-1:0] idx,
                           logic [SAMPLE_W-1:0] val);
    in_word_t w;
    w.mode = mode;
    w.coef_index = idx;
    w.value = val;
    input_words.insert(input_words.size(), w);
    words_pushed++;
    case (mode)
      MODE_LOAD: coef_set[idx] = 1'b1;
      MODE_SAMPLE: begin
        gen_pos++;
        if (gen_pos >= active_length()) begin
          gen_pos = 0;
          gen_tail = active_length() - active_hop();
        end
      end
      MODE_FLUSH: if (gen_pos == 0 && gen_tail != 0) gen_tail--;
      default: ;
    endcase
    if (mode != MODE_UNUSED) real_words++;
  endtask

  // never let a sample read a coefficient slot that was not loaded
  task automatic push_sample(logic [SAMPLE_W-1:0] val);
    if (!coef_set[gen_pos])
      push_word(MODE_LOAD, CIDX_W'(gen_pos), SAMPLE_W'($urandom_range(0, 65535)));
    push_word(MODE_SAMPLE, CIDX_W'($urandom_range(0, 1023)), val);
  endtask

  task automatic push_flush();
    push_word(MODE_FLUSH, CIDX_W'($urandom_range(0, 1023)), SAMPLE_W'($urandom_range(0, 65535)));
  endtask

  task automatic wait_idle();
    while (words_taken != words_pushed || due_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    // ring clear after reset or a finished tail
    while (item_stall) @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) len_reg = val;
    else hop_reg = val;
  endtask

  task automatic random_phase(int count);
    int target, r, n;
    logic [SAMPLE_W-1:0] v;
    target = real_words + count;
    while (real_words < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // a frame left past a shrunken window ends on its next sample
        if (gen_pos < active_length()) n = active_length() - gen_pos;
        else n = 1;
        if (n > 24) n = $urandom_range(1, 24);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
              0: v = 16'h8000;
              1: v = 16'h7FFF;
              2: v = 16'h0000;
              default: v = 16'hFFFF;
            endcase
          end else begin
            v = SAMPLE_W'($urandom_range(0, 65535));
          end
          push_sample(v);
        end
      end else if (r < 63) begin
        if (gen_pos == 0) repeat (gen_tail) push_flush();
      end else if (r < 75) begin
        if (gen_pos == 0 && gen_tail > 1) repeat ($urandom_range(1, gen_tail - 1)) push_flush();
      end else if (r < 87) begin
        push_word(MODE_LOAD, CIDX_W'($urandom_range(0, 1023)),
                  SAMPLE_W'($urandom_range(0, 65535)));
      end else if (r < 93) begin
        push_word(MODE_UNUSED, CIDX_W'($urandom_range(0, 1023)),
                  SAMPLE_W'($urandom_range(0, 65535)));
      end else if (r < 99) begin
        if (gen_pos != 0) push_flush();
      end else begin
        push_flush();
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] len_plan [10];
    logic [CFG_W-1:0] hop_plan [10];
    len_plan = '{11'd8, 11'd1, 11'd16, 11'd0, 11'd5, 11'd12, 11'd2047, 11'd3, 11'd1024, 11'd6};
    hop_plan = '{11'd3, 11'd1, 11'd16, 11'd0, 11'd2, 11'd2047, 11'd1000, 11'd1, 11'd1, 11'd4};
    len_reg = WINDOW_LENGTH_RESET;
    hop_reg = HOP_SIZE_RESET;
    clear_ring();
    foreach (coef_mem[i]) coef_mem[i] = '0;
    frame_pos = 0;
    tail_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: full-scale products, rounding at the half, bad flush
    push_word(MODE_LOAD, 10'd0, 16'h8000);
    push_word(MODE_LOAD, 10'd1, 16'h7FFF);
    push_word(MODE_LOAD, 10'd2, 16'h4000);
    push_word(MODE_LOAD, 10'd1023, 16'h0001);
    push_sample(16'h8000);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_word(MODE_LOAD, 10'd3, 16'h2000);
    push_sample(16'h0001);
    push_word(MODE_LOAD, 10'd4, 16'h2000);
    push_sample(16'hFFFF);
    push_word(MODE_UNUSED, 10'h3FF, 16'hFFFF);
    push_flush();

    // shrink the window under a partial frame, then drain and flush empty
    set_reg(REG_WINDOW_LENGTH, 11'd4);
    set_reg(REG_HOP_SIZE, 11'd2);
    push_sample(16'h1234);
    repeat (3) push_flush();
    repeat (4) push_sample(SAMPLE_W'($urandom_range(0, 65535)));
    push_flush();
    repeat (4) push_sample(SAMPLE_W'($urandom_range(0, 65535)));

    foreach (len_plan[i]) begin
      set_reg(REG_WINDOW_LENGTH, len_plan[i]);
      set_reg(REG_HOP_SIZE, hop_plan[i]);
      random_phase(PHASE_WORDS);
    end

    wait_idle();
    if (fail_count == 0) $display("windowed_overlap_add_top: match");
    else $display("windowed_overlap_add_top: mismatch");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("windowed_overlap_add_top: mismatch");
    $finish;
  end

endmodule
